### src/pixel_gamma_contrast_brightness_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamma / contrast / brightness pixel block
// Clocked on clk, disabled while rst_n is low. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef PIXEL_GAMMA_CONTRAST_BRIGHTNESS_ASSERT_SVH
`define PIXEL_GAMMA_CONTRAST_BRIGHTNESS_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PGCB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PGCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PGCB_ASSERT_IMPL(label, ante, cons, msg)
`define PGCB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/pgcb_pkg.sv
// ----------------------------------------------------------------------------
// pgcb_pkg
// Shared constants, types and elaboration-time table functions for the pixel adjuster.
// ----------------------------------------------------------------------------
package pgcb_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int FRAC_BITS  = 12;
  localparam int PMAX       = (1 << PIXEL_BITS) - 1;
  localparam int NUM_CODES  = 1 << PIXEL_BITS;
  localparam int NUM_LANES  = 3;

  localparam int A_W       = 20;            // log2 term, Q16, at most 8.0
  localparam int EXP_STEPS = 16;            // exp2 fraction bits
  localparam int R_W       = 31;            // exp2 product, Q30 up to 1.0
  localparam int PW_W      = 17;            // power result, Q16 up to 1.0
  localparam int Y_W       = 35;            // adjusted value, signed Q28
  localparam int OUT_SHIFT = 16 + FRAC_BITS;
  localparam int DIV_STEPS = PIXEL_BITS;

  localparam int LANE_LAT  = EXP_STEPS + 4;
  localparam int MERGE_LAT = DIV_STEPS + 3;
  localparam int TOT_LAT   = LANE_LAT + MERGE_LAT;

  typedef enum logic [2:0] {
    CFG_CONTRAST = 3'd0,
    CFG_BRIGHT   = 3'd1,
    CFG_GAMMA    = 3'd2,
    CFG_LUMA     = 3'd3,
    CFG_THREE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] contrast_gain;
    logic signed [13:0] brightness_offset;
    logic        [15:0] gamma_exponent;
  } adj_cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 constant 2^(-2^-k)
  function automatic logic [63:0] exp_const(input int k);
    logic [63:0] d;
    d = isqrt64(64'd1 << 59);
    for (int i = 1; i < k; i++) begin
      d = isqrt64(d << 30);
    end
    return d;
  endfunction

  // -log2(n) in Q16 for byte code x (n = x / PMAX in Q16)
  function automatic logic [63:0] log_term(input int x);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    n = (64'(x) * 64'd65536 + 64'(PMAX / 2)) / 64'(PMAX);
    if (n == 64'd0 || n >= 64'd65536) return 64'd0;
    e = 0;
    for (int j = 0; j < 15; j++) begin
      if ((n >> (e + 1)) != 64'd0) e = e + 1;
    end
    m = n << (30 - e);
    frac = 64'd0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (15 - i));
      end
    end
    return (64'(16 - e) << 16) - frac;
  endfunction

endpackage

### src/pixel_gamma_contrast_brightness.sv
// ----------------------------------------------------------------------------
// pixel_gamma_contrast_brightness
// Per-pixel gamma, contrast and brightness adjustment for grey or BGR pixels,
// with an optional mode that adjusts only V = max(B,G,R) and keeps hue.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (low bits first)
//  in_*      in   tdata: chan_blue[7:0], chan_green[15:8], chan_red[23:16]
//  out_*     out  tdata: res_blue[7:0], res_green[15:8], res_red[23:16]
//  cfg_*     in   index 0 contrast, 1 brightness, 2 gamma, 3 luma, 4 three
//
//  One pixel per clock while the skid register is empty. 32 register stages:
//  20 in the lane (log lookup, gamma multiply, 16-step exp2 product chain,
//  shift, gain), 11 in the merge (product, scale, saturation check,
//  8-step divider), 1 output register.
//  rst_n is synchronous; it clears valids and loads register defaults.
//  The pipeline stalls only once both the output register and the skid
//  register are full; in_tready is registered state.
// ----------------------------------------------------------------------------
`include "pixel_gamma_contrast_brightness_assert.svh"

module pixel_gamma_contrast_brightness (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // chan_blue, chan_green, chan_red
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // res_blue, res_green, res_red
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pgcb_pkg::*;

  // configuration registers
  logic [15:0]        contrast_r;
  logic signed [13:0] bright_r;
  logic [15:0]        gamma_r;
  logic               luma_r;
  logic               three_r;
  adj_cfg_t           cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r <= 16'd4096;
      bright_r   <= '0;
      gamma_r    <= 16'd4096;
      luma_r     <= 1'b0;
      three_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CONTRAST: contrast_r <= cfg_data;
        CFG_BRIGHT:   bright_r   <= cfg_data[13:0];
        CFG_GAMMA:    gamma_r    <= cfg_data;
        CFG_LUMA:     luma_r     <= cfg_data[0];
        CFG_THREE:    three_r    <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  assign cfg.contrast_gain     = contrast_r;
  assign cfg.brightness_offset = bright_r;
  assign cfg.gamma_exponent    = gamma_r;

  // pipeline advance: frozen only while the skid register holds a beat
  logic en;
  logic sk_valid_r;
  assign en        = !sk_valid_r;
  assign in_tready = en;

  // lane inputs; in luma mode lane 0 carries V
  logic [NUM_LANES-1:0][PIXEL_BITS-1:0] chan;
  logic [PIXEL_BITS-1:0]                vin;
  logic                                 luma_mode;
  assign chan[0]   = in_tdata[7:0];
  assign chan[1]   = in_tdata[15:8];
  assign chan[2]   = in_tdata[23:16];
  assign luma_mode = luma_r && three_r;

  always_comb begin
    vin = chan[0];
    if (chan[1] > vin) vin = chan[1];
    if (chan[2] > vin) vin = chan[2];
  end

  logic [NUM_LANES-1:0][Y_W-1:0] lane_y;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    pgcb_lane u_lane (
      .clk (clk),
      .en  (en),
      .cfg (cfg),
      .x   ((l == 0 && luma_mode) ? vin : chan[l]),
      .y   (lane_y[l])
    );
  end

  // channel bytes travel alongside the lanes
  logic [NUM_LANES-1:0][PIXEL_BITS-1:0] ch_dly_r [LANE_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      ch_dly_r[0] <= chan;
      for (int k = 1; k < LANE_LAT; k++) ch_dly_r[k] <= ch_dly_r[k-1];
    end
  end

  logic [NUM_LANES-1:0][PIXEL_BITS-1:0] merged;

  pgcb_merge u_merge (
    .clk  (clk),
    .en   (en),
    .luma (luma_r),
    .grey (!three_r),
    .y    (lane_y),
    .c    (ch_dly_r[LANE_LAT-1]),
    .res  (merged)
  );

  // beat valid through the whole pipe
  logic [TOT_LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_tvalid};
    end
  end

  // output register plus skid register
  logic        p_valid;
  logic [23:0] p_data;
  logic        out_valid_r, out_valid_nxt, sk_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt, sk_data_r, sk_data_nxt;

  assign p_valid = vld_r[TOT_LAT-1];
  assign p_data  = merged;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sk_valid_nxt  = sk_valid_r;
    sk_data_nxt   = sk_data_r;
    if (sk_valid_r) begin
      if (out_tready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = sk_data_r;
        sk_valid_nxt  = 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_nxt = p_valid;
      out_data_nxt  = p_data;
    end else if (p_valid) begin
      sk_valid_nxt = 1'b1;
      sk_data_nxt  = p_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    sk_data_r  <= sk_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PGCB_ASSERT_IMPL(a_skid_has_out, sk_valid_r, out_valid_r, "skid full with output empty")
  `PGCB_ASSERT_NEXT(a_skid_holds, sk_valid_r && !out_tready, sk_valid_r && $stable(sk_data_r), "skid beat lost")
  `PGCB_ASSERT_NEXT(a_pipe_frozen, sk_valid_r, $stable(vld_r), "pipe moved during stall")

endmodule

### src/pgcb_lane.sv
// ----------------------------------------------------------------------------
// pgcb_lane
// One channel: byte -> n^gamma via log2 table and exp2 product chain,
// then contrast gain and brightness offset.
// ----------------------------------------------------------------------------
module pgcb_lane (
  input  logic                              clk,
  input  logic                              en,
  input  pgcb_pkg::adj_cfg_t                cfg,
  input  logic [pgcb_pkg::PIXEL_BITS-1:0]   x,
  output logic signed [pgcb_pkg::Y_W-1:0]   y
);
  import pgcb_pkg::*;

  logic [A_W-1:0]   log_rom [NUM_CODES];
  logic [29:0]      dk      [EXP_STEPS];

  for (genvar g = 0; g < NUM_CODES; g++) begin : g_log
    assign log_rom[g] = A_W'(log_term(g));
  end
  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_dk
    assign dk[k] = 30'(exp_const(k + 1));
  end

  // stage 0: table lookup
  logic [A_W-1:0] a_r;
  logic           zero0_r, one0_r;

  // stage 1 and exp chain
  logic [R_W-1:0]       r_r    [EXP_STEPS+1];
  logic [15:0]          fp_r   [EXP_STEPS+1];
  logic [7:0]           ip_r   [EXP_STEPS+1];
  logic                 zero_r [EXP_STEPS+1];
  logic                 one_r  [EXP_STEPS+1];
  logic [R_W+29:0]      prod   [EXP_STEPS];

  logic [A_W+16:0]      qprod;
  logic [PW_W-1:0]      pw_r;
  logic [4:0]           sh;
  logic [R_W+1:0]       rr;
  logic [PW_W-1:0]      pw_nxt;
  logic [32:0]          gmul;
  logic signed [Y_W-1:0] y_r;

  assign qprod = A_W'(a_r) * 37'(cfg.gamma_exponent) + (37'd1 << (FRAC_BITS - 1));

  always_comb begin
    for (int k = 0; k < EXP_STEPS; k++) begin
      prod[k] = (R_W+30)'(r_r[k]) * (R_W+30)'(dk[k]) + ((R_W+30)'(1) << 29);
    end
  end

  // final shift of the exp2 mantissa by the integer part (0..17 reach here)
  always_comb begin
    sh = 5'(14 + ip_r[EXP_STEPS][4:0]);
    rr = (R_W+2)'(r_r[EXP_STEPS]) + ((R_W+2)'(1) << (sh - 5'd1));
    if (one_r[EXP_STEPS]) begin
      pw_nxt = PW_W'(65536);
    end else if (zero_r[EXP_STEPS] || ip_r[EXP_STEPS] >= 8'd18) begin
      pw_nxt = '0;
    end else begin
      pw_nxt = PW_W'(rr >> sh);
    end
  end

  assign gmul = pw_r * cfg.contrast_gain;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= log_rom[x];
      zero0_r <= (x == '0) && (cfg.gamma_exponent != '0);
      one0_r  <= (x == PIXEL_BITS'(PMAX)) || (cfg.gamma_exponent == '0);

      r_r[0]    <= R_W'(1) << 30;
      fp_r[0]   <= qprod[FRAC_BITS+15:FRAC_BITS];
      ip_r[0]   <= qprod[FRAC_BITS+23:FRAC_BITS+16];
      zero_r[0] <= zero0_r;
      one_r[0]  <= one0_r;
      for (int k = 1; k <= EXP_STEPS; k++) begin
        r_r[k]    <= fp_r[k-1][EXP_STEPS-k] ? prod[k-1][R_W+29:30] : r_r[k-1];
        fp_r[k]   <= fp_r[k-1];
        ip_r[k]   <= ip_r[k-1];
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end

      pw_r <= pw_nxt;
      y_r  <= $signed({2'b00, gmul})
            + $signed({{(Y_W-30){cfg.brightness_offset[13]}}, cfg.brightness_offset, 16'b0});
    end
  end

  assign y = y_r;

endmodule

### src/pgcb_merge.sv
// ----------------------------------------------------------------------------
// pgcb_merge
// Combines the lane results: byte conversion, or in luma mode rescaling of
// each channel by V'/V through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module pgcb_merge (
  input  logic                                              clk,
  input  logic                                              en,
  input  logic                                              luma,
  input  logic                                              grey,
  input  logic [pgcb_pkg::NUM_LANES-1:0][pgcb_pkg::Y_W-1:0]        y,
  input  logic [pgcb_pkg::NUM_LANES-1:0][pgcb_pkg::PIXEL_BITS-1:0] c,
  output logic [pgcb_pkg::NUM_LANES-1:0][pgcb_pkg::PIXEL_BITS-1:0] res
);
  import pgcb_pkg::*;

  localparam int PB   = PIXEL_BITS;
  localparam int P_W  = PB + Y_W - 1;
  localparam int N_W  = P_W + PB + 1;
  localparam int M_W  = N_W - OUT_SHIFT;
  localparam int RM_W = 2 * PB;

  function automatic logic [PB-1:0] to_byte(input logic [Y_W-1:0] v_in);
    logic [Y_W+PB:0] t;
    if ($signed(v_in) <= 0) return '0;
    t = ((Y_W+PB+1)'(v_in) << PB) - (Y_W+PB+1)'(v_in)
      + ((Y_W+PB+1)'(1) << (OUT_SHIFT - 1));
    t = t >> OUT_SHIFT;
    return (t > (Y_W+PB+1)'(PMAX)) ? PB'(PMAX) : t[PB-1:0];
  endfunction

  logic [PB-1:0] vmax;
  logic [PB-1:0] tb [NUM_LANES];
  logic          y0_pos;

  // stage 1
  logic [NUM_LANES-1:0][PB-1:0]  byte1_r;
  logic [NUM_LANES-1:0][P_W-1:0] p_r;
  logic                          div1_r;
  logic [PB-1:0]                 v1_r;
  // stage 2
  logic [NUM_LANES-1:0][PB-1:0]  byte2_r;
  logic [NUM_LANES-1:0][M_W-1:0] m_r;
  logic                          div2_r;
  logic [PB-1:0]                 v2_r;
  logic [N_W-1:0]                nsum [NUM_LANES];
  // divider stages, index 0 is the overflow check
  logic [NUM_LANES-1:0][PB-1:0]   dbyte_r [DIV_STEPS+1];
  logic [NUM_LANES-1:0][RM_W-1:0] rem_r   [DIV_STEPS+1];
  logic [NUM_LANES-1:0][PB-1:0]   q_r     [DIV_STEPS+1];
  logic [NUM_LANES-1:0]           ovf_r   [DIV_STEPS+1];
  logic                           ddiv_r  [DIV_STEPS+1];
  logic [PB-1:0]                  dv_r    [DIV_STEPS+1];

  always_comb begin
    vmax = c[0];
    if (c[1] > vmax) vmax = c[1];
    if (c[2] > vmax) vmax = c[2];
    for (int i = 0; i < NUM_LANES; i++) tb[i] = to_byte(y[i]);
    y0_pos = $signed(y[0]) > 0;
    for (int i = 0; i < NUM_LANES; i++) begin
      nsum[i] = (N_W'(p_r[i]) << PB) - N_W'(p_r[i]) + (N_W'(v1_r) << (OUT_SHIFT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: byte conversion, numerator product
      for (int i = 0; i < NUM_LANES; i++) begin
        if (grey) byte1_r[i] <= (i == 0) ? tb[0] : '0;
        else if (luma) byte1_r[i] <= tb[0];
        else byte1_r[i] <= tb[i];
        p_r[i] <= P_W'(c[i]) * P_W'(y[0][Y_W-2:0]);
      end
      div1_r <= luma && !grey && y0_pos && (vmax != '0);
      v1_r   <= vmax;

      // stage 2: scale by PMAX, add half divisor, drop the fraction
      for (int i = 0; i < NUM_LANES; i++) begin
        m_r[i] <= nsum[i][N_W-1:OUT_SHIFT];
      end
      byte2_r <= byte1_r;
      div2_r  <= div1_r;
      v2_r    <= v1_r;

      // stage 3: saturation check
      for (int i = 0; i < NUM_LANES; i++) begin
        ovf_r[0][i] <= m_r[i] >= M_W'({v2_r, PB'(0)});
        rem_r[0][i] <= m_r[i][RM_W-1:0];
      end
      q_r[0]     <= '0;
      dbyte_r[0] <= byte2_r;
      ddiv_r[0]  <= div2_r;
      dv_r[0]    <= v2_r;

      // one quotient bit per stage, most significant first
      for (int s = 1; s <= DIV_STEPS; s++) begin
        for (int i = 0; i < NUM_LANES; i++) begin
          if (rem_r[s-1][i] >= (RM_W'(dv_r[s-1]) << (DIV_STEPS - s))) begin
            rem_r[s][i] <= rem_r[s-1][i] - (RM_W'(dv_r[s-1]) << (DIV_STEPS - s));
            q_r[s][i]   <= q_r[s-1][i] | (PB'(1) << (DIV_STEPS - s));
          end else begin
            rem_r[s][i] <= rem_r[s-1][i];
            q_r[s][i]   <= q_r[s-1][i];
          end
          ovf_r[s][i] <= ovf_r[s-1][i];
        end
        dbyte_r[s] <= dbyte_r[s-1];
        ddiv_r[s]  <= ddiv_r[s-1];
        dv_r[s]    <= dv_r[s-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (!ddiv_r[DIV_STEPS]) res[i] = dbyte_r[DIV_STEPS][i];
      else if (ovf_r[DIV_STEPS][i]) res[i] = PB'(PMAX);
      else res[i] = q_r[DIV_STEPS][i];
    end
  end

endmodule
